// ===== hdl/psq_pkg.sv =====
package psq_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF = 32;

  // operation codes on the kind field
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_FREE   = 2'd2
  } kind_t;

  // result codes on the status field
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // what every cell of the sorted row does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

endpackage

// ===== hdl/pooled_sorted_priority_queue_unit.sv =====
// channel | signals                                   | transfer when
// --------+-------------------------------------------+--------------------------
// in      | in_valid, in_stall, kind, key, slot_to_free | in_valid && !in_stall
// out     | out_valid, out_stall, status, slot,       | out_valid && !out_stall
//         | head_key, entries                         |
//
// one operation per cycle: a row of DEPTH cells shifts all entries at once,
// so insert, pop and free each finish in the cycle of their transfer
// the result sits in one output register and shows in the cycle after the input
// rst (synchronous) marks every slot free and empties the queue at once
// a stalled result holds the input off; it is taken in the same cycle the
// output frees up, so an unstalled stream runs at one item per clock
module pooled_sorted_priority_queue_unit #(
  parameter int unsigned DEPTH    = psq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = psq_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] key,
  input  logic [3:0]  slot_to_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [31:0] head_key,
  output logic [4:0]  entries
);
  import psq_pkg::*;

  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // handshake
  logic in_fire;

  // queue fill level
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // operation decode
  logic             ins_ok;
  logic             pop_ok;
  logic             free_ok;
  cell_op_t         cell_op;

  // slot pool
  logic              any_free;
  logic [SLOT_W-1:0] grab;
  logic [SLOT_W-1:0] free_idx;

  // width adaptation between the fixed ports and the parameters
  logic [KEY_BITS+31:0] key_ext;
  logic [KEY_BITS-1:0]  new_key;
  logic [SLOT_W+3:0]    free_ext;
  logic [SLOT_W+3:0]    grab_ext;
  logic [SLOT_W+3:0]    head_slot_ext;
  logic [KEY_BITS+31:0] head_key_ext;
  logic [CNT_W+4:0]     count_ext;

  // cell row
  logic [KEY_BITS-1:0] cell_key  [DEPTH];
  logic [SLOT_W-1:0]   cell_slot [DEPTH];
  logic [DEPTH-1:0]    cell_lt;

  // output register
  status_t          status_reg;
  status_t          status_next;
  logic [3:0]       slot_reg;
  logic [3:0]       slot_next;
  logic [31:0]      head_key_reg;
  logic [31:0]      head_key_next;
  logic [4:0]       entries_reg;

  // a new transfer is taken whenever the output register is free or drains
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // key is taken modulo 2^KEY_BITS
  assign key_ext  = {{KEY_BITS{1'b0}}, key};
  assign new_key  = key_ext[KEY_BITS-1:0];

  // free of an out-of-range slot number is dropped
  assign free_ext = {{SLOT_W{1'b0}}, slot_to_free};
  assign free_idx = free_ext[SLOT_W-1:0];

  always_comb begin
    ins_ok  = 1'b0;
    pop_ok  = 1'b0;
    free_ok = 1'b0;
    case (kind_t'(kind))
      KIND_INSERT: ins_ok  = any_free && (count < CNT_W'(DEPTH));
      KIND_POP:    pop_ok  = (count != '0);
      KIND_FREE:   free_ok = (free_ext < (SLOT_W + 4)'(DEPTH));
      default: begin
        ins_ok  = 1'b0;
        pop_ok  = 1'b0;
        free_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cell_op    = CELL_HOLD;
    count_next = count;
    if (in_fire && ins_ok) begin
      cell_op    = CELL_INSERT;
      count_next = count + CNT_W'(1);
    end else if (in_fire && pop_ok) begin
      cell_op    = CELL_POP;
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  psq_slot_pool #(
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W)
  ) u_pool (
    .clk         (clk),
    .rst         (rst),
    .claim       (in_fire && ins_ok),
    .release_req (in_fire && free_ok),
    .release_idx (free_idx),
    .any_free    (any_free),
    .grab        (grab)
  );

  // sorted row: cell 0 holds the smallest key; an insert shifts the tail
  // one place right, a pop shifts the whole row one place left
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                left_lt;
    logic [KEY_BITS-1:0] left_key;
    logic [SLOT_W-1:0]   left_slot;
    logic [KEY_BITS-1:0] right_key;
    logic [SLOT_W-1:0]   right_slot;

    if (i == 0) begin : g_first
      assign left_lt   = 1'b0;
      assign left_key  = new_key;
      assign left_slot = grab;
    end else begin : g_inner
      assign left_lt   = cell_lt[i-1];
      assign left_key  = cell_key[i-1];
      assign left_slot = cell_slot[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key  = cell_key[i];
      assign right_slot = cell_slot[i];
    end else begin : g_body
      assign right_key  = cell_key[i+1];
      assign right_slot = cell_slot[i+1];
    end

    psq_cell #(
      .KEY_BITS (KEY_BITS),
      .SLOT_W   (SLOT_W)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .occupied   (count > CNT_W'(i)),
      .new_key    (new_key),
      .new_slot   (grab),
      .left_lt    (left_lt),
      .left_key   (left_key),
      .left_slot  (left_slot),
      .right_key  (right_key),
      .right_slot (right_slot),
      .cell_key   (cell_key[i]),
      .cell_slot  (cell_slot[i]),
      .lt         (cell_lt[i])
    );
  end

  // result fields, fitted to the fixed port widths
  assign grab_ext      = {4'b0, grab};
  assign head_slot_ext = {4'b0, cell_slot[0]};
  assign head_key_ext  = {32'b0, cell_key[0]};
  assign count_ext     = {5'b0, count_next};

  always_comb begin
    status_next   = ST_DONE;
    slot_next     = '0;
    head_key_next = '0;
    case (kind_t'(kind))
      KIND_INSERT: begin
        if (ins_ok) begin
          slot_next = grab_ext[3:0];
        end else begin
          status_next = ST_FULL;
        end
      end
      KIND_POP: begin
        if (pop_ok) begin
          slot_next     = head_slot_ext[3:0];
          head_key_next = head_key_ext[31:0];
        end else begin
          status_next = ST_EMPTY;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_reg   <= status_next;
      slot_reg     <= slot_next;
      head_key_reg <= head_key_next;
      entries_reg  <= count_ext[4:0];
    end
  end

  assign status   = status_reg;
  assign slot     = slot_reg;
  assign head_key = head_key_reg;
  assign entries  = entries_reg;

  // fill level stays within the row
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill level beyond depth");

  // a refused insert changes nothing in the row
  a_refused_insert: assert property (@(posedge clk) disable iff (rst)
    (in_fire && kind == KIND_INSERT && !ins_ok) |=> count == $past(count))
    else $error("refused insert changed the fill level");

  // a pending result reports the current fill level
  a_entries_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entries == count_ext[4:0] || in_fire)
    else $error("entries field out of step with the fill level");

  // every transfer in produces a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("transfer in without result");

  // head of the row is never above its neighbor
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> cell_key[0] <= cell_key[1])
    else $error("first two cells out of order");

endmodule

// ===== hdl/psq_cell.sv =====
module psq_cell #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned SLOT_W   = 4
) (
  input  logic                 clk,
  input  psq_pkg::cell_op_t    op,
  input  logic                 occupied,
  input  logic [KEY_BITS-1:0]  new_key,
  input  logic [SLOT_W-1:0]    new_slot,
  input  logic                 left_lt,
  input  logic [KEY_BITS-1:0]  left_key,
  input  logic [SLOT_W-1:0]    left_slot,
  input  logic [KEY_BITS-1:0]  right_key,
  input  logic [SLOT_W-1:0]    right_slot,
  output logic [KEY_BITS-1:0]  cell_key,
  output logic [SLOT_W-1:0]    cell_slot,
  output logic                 lt
);
  import psq_pkg::*;

  logic [KEY_BITS-1:0] cell_key_next;
  logic [SLOT_W-1:0]   cell_slot_next;

  // queued entry strictly below the new key stays in front of it
  assign lt = occupied && (cell_key < new_key);

  always_comb begin
    cell_key_next  = cell_key;
    cell_slot_next = cell_slot;
    case (op)
      CELL_INSERT: begin
        if (!lt) begin
          // left neighbor stays in front: this is the insertion point
          if (left_lt) begin
            cell_key_next  = new_key;
            cell_slot_next = new_slot;
          end else begin
            cell_key_next  = left_key;
            cell_slot_next = left_slot;
          end
        end
      end
      CELL_POP: begin
        cell_key_next  = right_key;
        cell_slot_next = right_slot;
      end
      default: begin
        cell_key_next  = cell_key;
        cell_slot_next = cell_slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_key  <= cell_key_next;
    cell_slot <= cell_slot_next;
  end

endmodule

// ===== hdl/psq_slot_pool.sv =====
module psq_slot_pool #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned SLOT_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              claim,
  input  logic              release_req,
  input  logic [SLOT_W-1:0] release_idx,
  output logic              any_free,
  output logic [SLOT_W-1:0] grab
);

  logic [DEPTH-1:0] free_map;
  logic [DEPTH-1:0] free_map_next;
  logic [DEPTH-1:0] lowest;
  logic [DEPTH-1:0] release_mask;

  // isolate the lowest free slot
  assign lowest   = free_map & (~free_map + DEPTH'(1));
  assign any_free = |free_map;

  always_comb begin
    grab = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      grab = grab | ({SLOT_W{lowest[i]}} & SLOT_W'(i));
    end
  end

  always_comb begin
    release_mask = '0;
    release_mask[release_idx] = release_req;
  end

  always_comb begin
    free_map_next = free_map;
    if (claim) begin
      free_map_next = free_map & ~lowest;
    end
    free_map_next = free_map_next | release_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else begin
      free_map <= free_map_next;
    end
  end

endmodule

// ===== dv/tb_pooled_sorted_priority_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_pooled_sorted_priority_queue_unit;
  import psq_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int POOL       = DEPTH_DEF;
  // the kind field has one code left over that the block must treat as a no-op
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int N_RANDOM   = 1800;
  localparam int MAX_PRINTS = 200;

  // one operation as it crosses the input channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [3:0]  slot;
  } queue_op_t;

  // one result as it crosses the output channel
  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] head_key;
    logic [4:0]  entries;
  } queue_result_t;

  // slot pool plus the sorted list, smallest key at position 0
  typedef struct packed {
    logic [POOL-1:0]             free_mask;
    logic [POOL-1:0][31:0]       keys;
    logic [POOL-1:0][3:0]        slots;
    logic [4:0]                  count;
  } queue_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_INSERT;
  logic [31:0] key = '0;
  logic [3:0]  slot_to_free = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [31:0] head_key;
  logic [4:0]  entries;

  // long receiver hold-off, driven by its own process
  logic        hold_off = 1'b0;

  queue_op_t     ops_to_send[$];
  queue_result_t awaited_results[$];
  logic [3:0]    released_slots[$];

  // separate copies of the queue: one steers stimulus, one predicts results
  queue_state_t  plan_state;
  queue_state_t  live_state;

  int n_items    = 0;
  int n_accepted = 0;
  int err_count  = 0;
  int tx_gap     = 0;
  int tx_calm    = 0;
  int rx_gap     = 0;
  int rx_calm    = 0;

  pooled_sorted_priority_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .key          (key),
    .slot_to_free (slot_to_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot         (slot),
    .head_key     (head_key),
    .entries      (entries)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // one operation on the queue: returns its result and the state after it
  function automatic queue_result_t pq_apply(input queue_state_t cur, input queue_op_t op,
                                             output queue_state_t nxt);
    queue_result_t r;
    int grab;
    int pos;
    int i;
    nxt = cur;
    r = '0;
    r.status = ST_DONE;
    case (op.kind)
      KIND_INSERT: begin
        grab = -1;
        for (i = 0; i < POOL; i++) begin
          if (grab < 0 && cur.free_mask[i]) grab = i;
        end
        // no free slot, or the list already holds DEPTH entries
        if (grab < 0 || cur.count >= POOL) begin
          r.status = ST_FULL;
        end else begin
          nxt.free_mask[grab] = 1'b0;
          pos = 0;
          // strict compare: a new key lands ahead of equal keys
          while (pos < cur.count && cur.keys[pos] < op.key) pos++;
          for (i = cur.count; i > pos; i--) begin
            nxt.keys[i]  = cur.keys[i-1];
            nxt.slots[i] = cur.slots[i-1];
          end
          nxt.keys[pos]  = op.key;
          nxt.slots[pos] = grab[3:0];
          nxt.count      = cur.count + 5'd1;
          r.slot         = grab[3:0];
        end
      end
      KIND_POP: begin
        if (cur.count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_key = cur.keys[0];
          r.slot     = cur.slots[0];
          for (i = 0; i + 1 < cur.count; i++) begin
            nxt.keys[i]  = cur.keys[i+1];
            nxt.slots[i] = cur.slots[i+1];
          end
          nxt.count = cur.count - 5'd1;
        end
      end
      KIND_FREE: begin
        // a slot still queued is released too; its entry stays in the list
        if (op.slot < POOL) nxt.free_mask[op.slot] = 1'b1;
      end
      default: begin
      end
    endcase
    r.entries = nxt.count;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // small keys give plenty of ties, plus the two extremes
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(0, 15);
    if (r < 33) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  // queue one operation and track what the pool will look like after it
  task automatic add_op(input logic [1:0] k, input logic [31:0] kv, input logic [3:0] s);
    queue_op_t     op;
    queue_result_t r;
    op.kind = k;
    op.key  = kv;
    op.slot = s;
    r = pq_apply(plan_state, op, plan_state);
    // popped slots are the ones a well-behaved user frees next
    if (k == KIND_POP && r.status == ST_DONE) released_slots.push_back(r.slot);
    ops_to_send.push_back(op);
    n_items++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // stimulus: directed corners first, then random phases of fill and drain
  initial begin : stimulus
    int n_counted;
    int phase_left;
    bit filling;
    int r;
    int idx;
    int i;
    plan_state           = '0;
    plan_state.free_mask = '1;
    live_state           = plan_state;

    add_op(KIND_POP, $urandom, $urandom);            // pop on empty queue
    add_op(KIND_UNUSED, $urandom, $urandom);         // unused kind code
    add_op(KIND_FREE, $urandom, 4'd5);               // free of a slot already free
    // fill all slots: extremes, alternating bits and a run of equal keys
    add_op(KIND_INSERT, 32'h0000_0000, $urandom);
    add_op(KIND_INSERT, 32'hFFFF_FFFF, $urandom);
    add_op(KIND_INSERT, 32'h0000_0100, $urandom);
    add_op(KIND_INSERT, 32'h0000_0100, $urandom);
    add_op(KIND_INSERT, 32'h0000_0100, $urandom);
    add_op(KIND_INSERT, 32'hAAAA_AAAA, $urandom);
    add_op(KIND_INSERT, 32'h5555_5555, $urandom);
    add_op(KIND_INSERT, 32'h7FFF_FFFF, $urandom);
    add_op(KIND_INSERT, 32'h8000_0000, $urandom);
    add_op(KIND_INSERT, 32'h0000_0001, $urandom);
    add_op(KIND_INSERT, 32'hFFFF_FFFE, $urandom);
    for (i = 0; i < 5; i++) add_op(KIND_INSERT, $urandom, $urandom);
    add_op(KIND_INSERT, 32'h1234, $urandom);         // refused, pool empty
    add_op(KIND_FREE, $urandom, 4'd3);               // free a slot still queued
    add_op(KIND_INSERT, 32'h0000_0100, $urandom);    // refused, list full
    add_op(KIND_POP, $urandom, $urandom);
    add_op(KIND_INSERT, 32'h0000_0100, $urandom);    // reuses slot 3, ahead of the ties
    add_op(KIND_POP, $urandom, $urandom);
    add_op(KIND_POP, $urandom, $urandom);
    add_op(KIND_FREE, $urandom, 4'd15);              // still queued
    add_op(KIND_FREE, $urandom, 4'd0);               // popped earlier

    n_counted  = 0;
    phase_left = 0;
    filling    = 1'b1;
    while (n_counted < N_RANDOM) begin
      if (phase_left == 0) begin
        filling    = ($urandom_range(0, 1) != 0);
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // ignored by the block, not counted
        add_op(KIND_UNUSED, $urandom, $urandom);
      end else begin
        n_counted++;
        if (r < (filling ? 58 : 25)) begin
          add_op(KIND_INSERT, pick_key(), $urandom);
        end else if (r < (filling ? 76 : 75)) begin
          add_op(KIND_POP, $urandom, $urandom);
        end else if (released_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, released_slots.size() - 1);
          add_op(KIND_FREE, $urandom, released_slots[idx]);
          released_slots.delete(idx);
        end else begin
          // stray free: slot may be free already or still queued
          add_op(KIND_FREE, $urandom, $urandom_range(0, POOL - 1));
        end
      end
    end

    // drain: everything sent and every result seen, then a short settle
    while (n_accepted < n_items || awaited_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // sender: presents queued operations, predicts each one on its transfer
  always @(posedge clk) begin : driver
    queue_op_t     op;
    queue_result_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        // transfer happened on this edge
        op.kind = kind;
        op.key  = key;
        op.slot = slot_to_free;
        r = pq_apply(live_state, op, live_state);
        awaited_results.push_back(r);
        n_accepted++;
      end
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(0, 199) == 0) tx_calm = $urandom_range(40, 150);
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid     <= 1'b0;
        kind         <= $urandom;
        key          <= $urandom;
        slot_to_free <= $urandom;
      end else if (ops_to_send.size() != 0) begin
        op = ops_to_send.pop_front();
        in_valid     <= 1'b1;
        kind         <= op.kind;
        key          <= op.key;
        slot_to_free <= op.slot;
        tx_gap = (tx_calm > 0) ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: checks each transfer against the oldest prediction, drives stall
  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with none awaited, status", status, 0);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
          if (head_key !== want.head_key) report_mismatch("head_key", head_key, want.head_key);
          if (entries !== want.entries) report_mismatch("entries", entries, want.entries);
        end
      end
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(40, 150);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        rx_gap = (rx_calm > 0) ? 0 : idle_len();
        if (rx_gap > 0) begin
          rx_gap--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // back-pressure: hold the output for a long stretch mid-run so the block
  // fills and stalls its input while the sender keeps offering
  initial begin : back_pressure
    wait (!rst);
    wait (n_accepted >= 600);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #(800_000 * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/psq_pkg.sv
hdl/psq_cell.sv
hdl/psq_slot_pool.sv
hdl/pooled_sorted_priority_queue_unit.sv
dv/tb_pooled_sorted_priority_queue_unit.sv
